// File: hw/rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and the arctangent table for the odometry core.
// ----------------------------------------------------------------------------
package odo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_BITS   = 32;
   localparam int STEP_W       = 5;
   localparam int CW           = 34;   // CORDIC x, y, z width
   localparam int MUL_W        = 36;   // shared multiplier operand width
   localparam int PROD_W       = 2 * MUL_W;

   localparam logic [31:0] ANGLE_MASK  =
      32'(~((33'd1 << (32 - ANGLE_BITS)) - 33'd1));
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [MUL_W-1:0]     RAD_TO_TURN = 36'd683565276;

   localparam logic [1:0] CSR_SPEED_PER_RPM = 2'd0;
   localparam logic [1:0] CSR_INVERSE_GAUGE = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORD,
      ST_MUL_V,
      ST_MUL_S,
      ST_MUL_W,
      ST_MUL_XC,
      ST_MUL_XD,
      ST_MUL_YC,
      ST_MUL_YD,
      ST_MUL_R,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_HEAD,
      ST_DONE
   } odo_state_type;

   typedef struct packed {
      logic               load;
      logic               step;
      logic [STEP_W-1:0]  idx;
   } odo_cordic_ctl_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10680862;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41721;
         5'd15: r = 32'd20860;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2607;
         5'd19: r = 32'd1303;
         5'd20: r = 32'd651;
         5'd21: r = 32'd325;
         5'd22: r = 32'd162;
         5'd23: r = 32'd81;
         5'd24: r = 32'd40;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd2;
         5'd29: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic
// Rotation-mode CORDIC, one micro-rotation per step, giving cos and sin.
// ----------------------------------------------------------------------------
module odo_cordic
   import odo_pkg::*;
(
   input  logic                  clock,
   input  odo_cordic_ctl_type    ctl,
   input  logic [31:0]           angle,
   output logic signed [CW-1:0]  cos_out,
   output logic signed [CW-1:0]  sin_out
);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                 flip_ff, flip_in;
   logic signed [CW-1:0] z0, xs, ys, at;

   always_comb begin
      z0      = CW'($signed(angle & ANGLE_MASK));
      xs      = x_ff >>> ctl.idx;
      ys      = y_ff >>> ctl.idx;
      at      = CW'(atan_turn(ctl.idx));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      if (ctl.load) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         flip_in = 1'b0;
         z_in    = z0;
         // fold angles beyond a right angle into the front half-plane
         if (z0 > (CW'(1) <<< 30)) begin
            z_in    = z0 - (CW'(1) <<< 31);
            flip_in = 1'b1;
         end else if (z0 < -(CW'(1) <<< 30)) begin
            z_in    = z0 + (CW'(1) <<< 31);
            flip_in = 1'b1;
         end
      end else if (ctl.step) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// File: hw/rtl/differential_odometry_core.sv
// ----------------------------------------------------------------------------
// differential_odometry_core
// Differential-drive odometry: wheel rpm to speeds, pose integration with a
// CORDIC heading rotation, one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  rpm_left, rpm_right, elapsed_time
//   rsp      out        rsp_valid/rsp_stall  pos_x, pos_y, heading, speeds
//   csr      in         csr_we               csr_index, csr_wdata
//
// A request runs through the CORDIC step loop, then the ten passes through the
// one shared multiplier and the heading update before the response is offered;
// the response then waits until it is taken. The core goes back to idle before
// it accepts the next request, so requests do not overlap. req_stall is high
// from accept until the response is taken. Reset (synchronous) clears the pose
// and the sequencer and resets the configuration registers; a stalled response
// holds its fields.
// ----------------------------------------------------------------------------
module differential_odometry_core
   import odo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_rpm_left,
   input  logic signed [15:0]  req_rpm_right,
   input  logic [15:0]         req_elapsed_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [39:0]  rsp_pos_x,
   output logic signed [39:0]  rsp_pos_y,
   output logic [31:0]         rsp_heading,
   output logic signed [31:0]  rsp_lin_speed,
   output logic signed [31:0]  rsp_ang_speed,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] a);
      logic signed [31:0] r;
      if (a > PROD_W'(32'sh7FFF_FFFF))      r = 32'sh7FFF_FFFF;
      else if (a < PROD_W'(32'sh8000_0000)) r = 32'sh8000_0000;
      else                                  r = a[31:0];
      return r;
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [40:0] a);
      logic signed [39:0] r;
      if (a > 41'(POS_MAX))      r = POS_MAX;
      else if (a < 41'(POS_MIN)) r = POS_MIN;
      else                       r = a[39:0];
      return r;
   endfunction

   odo_state_type        state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [31:0]          spr_ff;
   logic [23:0]          igauge_ff;
   logic signed [15:0]   rl_ff, rr_ff;
   logic [15:0]          dt_ff;
   logic signed [39:0]   x_ff, y_ff;
   logic [31:0]          head_ff, turn_ff;
   logic signed [31:0]   v_ff, w_ff;
   logic [31:0]          mag_ff;
   logic                 neg_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [CW-1:0]    cos_val, sin_val;
   logic signed [PROD_W-1:0] prod_sh16, prod_sh30;
   logic signed [47:0]      rad;
   logic [47:0]             rad_abs;
   odo_cordic_ctl_type      cctl;

   odo_cordic u_cordic (
      .clock   (clock),
      .ctl     (cctl),
      .angle   (head_ff),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   assign prod_sh16 = prod_ff >>> 16;
   assign prod_sh30 = prod_ff >>> 30;
   assign rad       = prod_ff[47:0];
   // magnitude of the heading step, taken straight off the product
   assign rad_abs   = rad[47] ? 48'(-rad) : 48'(rad);

   // sequencer and shared multiplier operand select
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cctl      = '{load: 1'b0, step: 1'b0, idx: step_ff};
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cctl.load = 1'b1;
               step_in   = '0;
               state_in  = ST_CORD;
            end
         end
         ST_CORD: begin
            cctl.step = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_MUL_V;
         end
         ST_MUL_V: begin
            mul_a    = MUL_W'(17'(rl_ff) - 17'(rr_ff));
            mul_b    = MUL_W'(spr_ff);
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            mul_a    = MUL_W'(-(18'(rl_ff) + 18'(rr_ff)));
            mul_b    = MUL_W'(spr_ff);
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            mul_a    = MUL_W'($signed(prod_sh16[33:0]));
            mul_b    = MUL_W'(igauge_ff);
            state_in = ST_MUL_XC;
         end
         ST_MUL_XC: begin
            mul_a    = MUL_W'(v_ff);
            mul_b    = MUL_W'(cos_val);
            state_in = ST_MUL_XD;
         end
         ST_MUL_XD: begin
            mul_a    = MUL_W'($signed(prod_sh30[34:0]));
            mul_b    = MUL_W'(dt_ff);
            state_in = ST_MUL_YC;
         end
         ST_MUL_YC: begin
            mul_a    = MUL_W'(v_ff);
            mul_b    = MUL_W'(sin_val);
            state_in = ST_MUL_YD;
         end
         ST_MUL_YD: begin
            mul_a    = MUL_W'($signed(prod_sh30[34:0]));
            mul_b    = MUL_W'(dt_ff);
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            mul_a    = MUL_W'(w_ff);
            mul_b    = MUL_W'(dt_ff);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_a    = MUL_W'(rad_abs[47:32]);
            mul_b    = RAD_TO_TURN;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mul_a    = MUL_W'(mag_ff);
            mul_b    = RAD_TO_TURN;
            state_in = ST_HEAD;
         end
         ST_HEAD: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff    <= '0;
         igauge_ff <= 24'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED_PER_RPM: spr_ff    <= csr_wdata;
            CSR_INVERSE_GAUGE: igauge_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // datapath: capture the product and the request, then the speeds and heading terms
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == ST_IDLE && req_valid) begin
         rl_ff <= req_rpm_left;
         rr_ff <= req_rpm_right;
         dt_ff <= req_elapsed_time;
      end
      if (state_ff == ST_MUL_S)  v_ff <= sat32(prod_ff >>> 17);
      if (state_ff == ST_MUL_XC) w_ff <= sat32(prod_sh16);
      if (state_ff == ST_MUL_HI) begin
         neg_ff <= rad[47];
         mag_ff <= rad_abs[31:0];
      end
      if (state_ff == ST_MUL_LO) turn_ff <= prod_ff[31:0];
   end

   // pose state: reset clears it, updates land on their own steps
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         head_ff <= '0;
      end else begin
         if (state_ff == ST_MUL_YC)
            x_ff <= sat40(41'(x_ff) + 41'($signed(prod_sh16[35:0])));
         if (state_ff == ST_MUL_R)
            y_ff <= sat40(41'(y_ff) + 41'($signed(prod_sh16[35:0])));
         if (state_ff == ST_HEAD)
            head_ff <= neg_ff ? head_ff - (turn_ff + prod_ff[63:32])
                              : head_ff + (turn_ff + prod_ff[63:32]);
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_DONE);
   assign rsp_pos_x     = x_ff;
   assign rsp_pos_y     = y_ff;
   assign rsp_heading   = head_ff;
   assign rsp_lin_speed = v_ff;
   assign rsp_ang_speed = w_ff;

`ifndef SYNTHESIS
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORD) |-> (step_ff < STEP_W'(CORDIC_STEPS)))
      else $error("cordic step index out of range");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");
`endif

endmodule
